FILE: hdl/bounded_array_list_engine_macros.svh
// ----------------------------------------------------------------------------
// bounded array list engine assertion macros
// shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

`define ALE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ALE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define ALE_ASSERT(lbl, clk, rst_n, prop, msg)

`define ALE_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

FILE: hdl/ale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// shared types and constants of the bounded array list engine
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;
    localparam int SCAN_GROUP = 16;
    localparam int SG_W       = $clog2(SCAN_GROUP);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_ERASE      = 3'd5,
        OP_FIND       = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
    } t_shift;

endpackage

FILE: hdl/ale_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale command and response interfaces
// valid/ready channels carrying list commands and their results
// ----------------------------------------------------------------------------
interface ale_cmd_if #(
    parameter int CNT_W = 7
) ();
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [CNT_W-1:0]   position;
    logic signed [31:0] value;

    modport source (output valid, op, position, value, input ready);
    modport sink   (input valid, op, position, value, output ready);
endinterface

interface ale_rsp_if #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) ();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic             found;
    logic [IDX_W-1:0] match_index;
    logic [CNT_W-1:0] count_after;

    modport source (output valid, status, found, match_index, count_after, input ready);
    modport sink   (input valid, status, found, match_index, count_after, output ready);
endinterface

FILE: hdl/bounded_array_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// ordered list of signed 32-bit values in a row of shift cells with a count
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  i_cmd    in   valid/ready  op, position, value
//  o_rsp    out  valid/ready  status, found, match_index, count_after
//
//  push, pop, insert and erase shift the cells at once; pop back only drops the count
//  find compares in all cells, then runs a priority scan of
//  16 match bits per cycle
//  one item at a time; result sits in an output register, the next item is
//  taken when that register is empty or drains in the same cycle
//  reset clears the count and the handshake; entries need no clearing
// ----------------------------------------------------------------------------
module bounded_array_list_engine
    import ale_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ale_cmd_if.sink    i_cmd,
    ale_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_shift              w_shift;
    logic [CNT_W-1:0]    w_pos;
    logic [CNT_W-1:0]    w_count;
    logic [CAPACITY-1:0] w_match;
    logic [DATA_W-1:0]   w_data [CAPACITY];
    logic [DATA_W-1:0]   w_value;

    assign w_value = i_cmd.value;

    ale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_rsp   (o_rsp),
        .i_match (w_match),
        .o_shift (w_shift),
        .o_pos   (w_pos),
        .o_count (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int LEFT  = (g == 0) ? 0 : g - 1;
        localparam int RIGHT = (g == CAPACITY - 1) ? g : g + 1;

        ale_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_pos   (w_pos),
            .i_count (w_count),
            .i_value (w_value),
            .i_left  (w_data[LEFT]),
            .i_right (w_data[RIGHT]),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

endmodule

FILE: hdl/ale_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_cell
// one list slot: holds an entry, shifts from a neighbor, compares for find
// ----------------------------------------------------------------------------
module ale_cell
    import ale_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic              i_clk,
    input  t_shift            i_shift,
    input  logic [CNT_W-1:0]  i_pos,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic              o_match
);

    localparam logic [CNT_W-1:0] C_IDX = CNT_W'(IDX);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_shift.ins) begin
            if (C_IDX > i_pos) begin
                n_data = i_left;
            end else if (C_IDX == i_pos) begin
                n_data = i_value;
            end
        end else if (i_shift.del && (C_IDX >= i_pos)) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (C_IDX < i_count) && (r_data == i_value);

endmodule

FILE: hdl/ale_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ctrl
// command decode, count, shift control, find scan and result register
// ----------------------------------------------------------------------------
`include "bounded_array_list_engine_macros.svh"

module ale_ctrl
    import ale_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    ale_cmd_if.sink                            i_cmd,
    ale_rsp_if.source                          o_rsp,
    input  logic [CAPACITY-1:0]                i_match,
    output t_shift                             o_shift,
    output logic [$clog2(CAPACITY+1)-1:0]      o_pos,
    output logic [$clog2(CAPACITY+1)-1:0]      o_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int NGRP  = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int NPAD  = NGRP * SCAN_GROUP;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [NPAD-1:0]     r_match, n_match;
    logic [GRP_W-1:0]    r_grp, n_grp;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic                r_out_found, n_out_found;
    logic [IDX_W-1:0]    r_out_idx, n_out_idx;
    logic [CNT_W-1:0]    r_out_count, n_out_count;

    logic                w_ready;
    logic                w_fire;
    t_op                 w_op;
    logic                w_full;
    logic                w_empty;
    t_status             w_status;
    logic [SCAN_GROUP-1:0] w_bits;
    logic [SG_W-1:0]     w_enc;
    logic                w_hit;
    logic                w_last;
    logic [GRP_W+SG_W-1:0] w_idx_full;

    assign w_op    = t_op'(i_cmd.op);
    assign w_fire  = i_cmd.valid && w_ready;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // group priority encoder
    assign w_bits = r_match[r_grp*SCAN_GROUP +: SCAN_GROUP];
    always_comb begin
        w_enc = '0;
        for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
            if (w_bits[k]) begin
                w_enc = SG_W'(k);
            end
        end
    end
    assign w_hit      = |w_bits;
    assign w_last     = (r_grp == GRP_W'(NGRP - 1));
    assign w_idx_full = {r_grp, w_enc};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire && (w_op == OP_FIND)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready = 1'b0;
        unique case (r_state)
            S_IDLE:  w_ready = !r_out_valid || o_rsp.ready;
            S_SCAN:  w_ready = 1'b0;
            default: w_ready = 1'b0;
        endcase
    end

    // datapath next values
    always_comb begin
        n_count      = r_count;
        n_match      = r_match;
        n_grp        = r_grp;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_idx    = r_out_idx;
        n_out_count  = r_out_count;
        o_shift      = '0;
        o_pos        = '0;
        w_status     = ST_OK;
        if (w_fire) begin
            unique case (w_op)
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        o_shift.ins = 1'b1;
                        o_pos       = r_count;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        o_shift.ins = 1'b1;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        o_shift.del = 1'b1;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                OP_INSERT: begin
                    priority if (w_full) begin
                        w_status = ST_FULL;
                    end else if (i_cmd.position > r_count) begin
                        w_status = ST_RANGE;
                    end else begin
                        o_shift.ins = 1'b1;
                        o_pos       = i_cmd.position;
                        n_count     = r_count + CNT_W'(1);
                    end
                end
                OP_ERASE: begin
                    priority if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else if (i_cmd.position >= r_count) begin
                        w_status = ST_RANGE;
                    end else begin
                        o_shift.del = 1'b1;
                        o_pos       = i_cmd.position;
                        n_count     = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    w_status = ST_OK;
                end
            endcase
            if (w_op == OP_FIND) begin
                n_match = NPAD'(i_match);
                n_grp   = '0;
            end else begin
                n_out_valid  = 1'b1;
                n_out_status = w_status;
                n_out_found  = 1'b0;
                n_out_idx    = '0;
                n_out_count  = n_count;
            end
        end else if (r_state == S_SCAN) begin
            n_grp = r_grp + GRP_W'(1);
            if (w_hit || w_last) begin
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_found  = w_hit;
                n_out_idx    = w_hit ? IDX_W'(w_idx_full) : '0;
                n_out_count  = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match      <= n_match;
        r_grp        <= n_grp;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_idx    <= n_out_idx;
        r_out_count  <= n_out_count;
    end

    assign i_cmd.ready       = w_ready;
    assign o_count           = r_count;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.match_index = r_out_idx;
    assign o_rsp.count_after = r_out_count;

    `ALE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `ALE_ASSERT(a_count_needs_item, i_clk, i_rst_n, (r_count != $past(r_count)) |-> $past(w_fire), "count moved without an item")
    `ALE_ASSERT_NEVER(a_scan_with_result, i_clk, i_rst_n, (r_state == S_SCAN) && r_out_valid, "result pending during find scan")
    `ALE_ASSERT(a_found_ok, i_clk, i_rst_n, (r_out_valid && r_out_found) |-> (r_out_status == ST_OK), "found with bad status")

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives list commands into the bounded array list engine with random gaps
// on both channels and checks each result against a list model kept in a
// scoreboard: directed corner cases first, then phases that fill and drain
// ----------------------------------------------------------------------------
module testbench;
    import ale_pkg::*;

    localparam int CAP          = 64;
    localparam int CNT_W        = 7;
    localparam int IDX_W        = 6;
    localparam int N_RANDOM     = 1130;
    localparam int PHASE_LEN    = 130;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        t_status          status;
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic [CNT_W-1:0] count_after;
    } t_result;

    class list_scoreboard;
        logic [DATA_W-1:0] cells[CAP];
        int unsigned       count;
        t_result           pending[$];
        int                errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function void open_slot(int unsigned pos, logic [DATA_W-1:0] val);
            for (int i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
        endfunction

        function void close_slot(int unsigned pos);
            for (int i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
        endfunction

        function void note_cmd(logic [OP_W-1:0] op, logic [CNT_W-1:0] pos,
                               logic [DATA_W-1:0] val);
            t_result r;
            r.status      = ST_OK;
            r.found       = 1'b0;
            r.match_index = '0;
            case (op)
                OP_PUSH_BACK: begin
                    if (count >= CAP) r.status = ST_FULL;
                    else open_slot(count, val);
                end
                OP_POP_BACK: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else count--;
                end
                OP_PUSH_FRONT: begin
                    if (count >= CAP) r.status = ST_FULL;
                    else open_slot(0, val);
                end
                OP_POP_FRONT: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else close_slot(0);
                end
                OP_INSERT: begin
                    if (count >= CAP) r.status = ST_FULL;
                    else if (pos > count) r.status = ST_RANGE;
                    else open_slot(pos, val);
                end
                OP_ERASE: begin
                    if (count == 0) r.status = ST_EMPTY;
                    else if (pos >= count) r.status = ST_RANGE;
                    else close_slot(pos);
                end
                OP_FIND: begin
                    for (int i = 0; i < count; i++) begin
                        if (!r.found && cells[i] == val) begin
                            r.found       = 1'b1;
                            r.match_index = IDX_W'(i);
                        end
                    end
                end
                default: ;
            endcase
            r.count_after = CNT_W'(count);
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_rsp(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending, status %0d count %0d",
                                 got.status, got.count_after));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.found !== want.found)
                report($sformatf("found %0d, want %0d", got.found, want.found));
            if (got.match_index !== want.match_index)
                report($sformatf("match_index %0d, want %0d",
                                 got.match_index, want.match_index));
            if (got.count_after !== want.count_after)
                report($sformatf("count_after %0d, want %0d",
                                 got.count_after, want.count_after));
        endtask

        function int unsigned outstanding();
            return pending.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ale_cmd_if #(.CNT_W(CNT_W))                cmd_if ();
    ale_rsp_if #(.IDX_W(IDX_W), .CNT_W(CNT_W)) rsp_if ();

    bounded_array_list_engine #(
        .CAPACITY(CAP)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_rsp   (rsp_if.source)
    );

    list_scoreboard sb;
    bit             no_idle;
    bit             hold_req;
    bit             hold_done;
    int             idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        if (no_idle) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // small pool gives repeated values so find sees several matches
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return DATA_W'($urandom_range(0, 7));
        if (roll < 50) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic pick_cmd(input bit grow, output logic [OP_W-1:0] op,
                            output logic [CNT_W-1:0] pos, output logic [DATA_W-1:0] val);
        int roll;
        int unsigned cnt;
        cnt  = sb.count;
        roll = $urandom_range(0, 99);
        if (grow) begin
            if      (roll < 25) op = OP_PUSH_BACK;
            else if (roll < 45) op = OP_PUSH_FRONT;
            else if (roll < 70) op = OP_INSERT;
            else if (roll < 75) op = OP_POP_BACK;
            else if (roll < 80) op = OP_POP_FRONT;
            else if (roll < 88) op = OP_ERASE;
            else if (roll < 98) op = OP_FIND;
            else                op = OP_UNUSED;
        end else begin
            if      (roll < 5)  op = OP_PUSH_BACK;
            else if (roll < 10) op = OP_PUSH_FRONT;
            else if (roll < 18) op = OP_INSERT;
            else if (roll < 40) op = OP_POP_BACK;
            else if (roll < 60) op = OP_POP_FRONT;
            else if (roll < 85) op = OP_ERASE;
            else if (roll < 98) op = OP_FIND;
            else                op = OP_UNUSED;
        end
        val = pick_value();
        pos = CNT_W'($urandom_range(0, CAP));
        if (op == OP_INSERT && $urandom_range(0, 99) < 85)
            pos = CNT_W'($urandom_range(0, cnt));
        if (op == OP_ERASE && cnt > 0 && $urandom_range(0, 99) < 85)
            pos = CNT_W'($urandom_range(0, cnt - 1));
        if (op == OP_FIND && cnt > 0 && $urandom_range(0, 99) < 60)
            val = sb.cells[$urandom_range(0, cnt - 1)];
    endtask

    task automatic send_cmd(logic [OP_W-1:0] op, logic [CNT_W-1:0] pos,
                            logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.op       <= op;
        cmd_if.position <= pos;
        cmd_if.value    <= val;
        do @(posedge i_clk); while (!cmd_if.ready);
        sb.note_cmd(op, pos, val);
    endtask

    // result side, with one long hold-off so the engine backs up
    initial begin
        int      gap;
        t_result got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = pick_gap();
            end
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            got.status      = t_status'(rsp_if.status);
            got.found       = rsp_if.found;
            got.match_index = rsp_if.match_index;
            got.count_after = rsp_if.count_after;
            sb.check_rsp(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [OP_W-1:0]   op;
        logic [CNT_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        int                phase;
        sb              = new();
        no_idle         = 1'b0;
        hold_req        = 1'b0;
        hold_done       = 1'b0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.op       = '0;
        cmd_if.position = '0;
        cmd_if.value    = '0;
        rsp_if.ready    = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corners
        send_cmd(OP_FIND,       7'd0,  32'h0000_0000);
        send_cmd(OP_POP_BACK,   7'd0,  32'h0000_0000);
        send_cmd(OP_POP_FRONT,  7'd0,  32'h0000_0000);
        send_cmd(OP_ERASE,      7'd0,  32'h0000_0000);
        send_cmd(OP_UNUSED,     7'd64, 32'hffff_ffff);
        send_cmd(OP_INSERT,     7'd1,  32'h1234_5678);
        // build a short list with extreme values and a duplicate
        send_cmd(OP_INSERT,     7'd0,  32'h7fff_ffff);
        send_cmd(OP_PUSH_BACK,  7'd0,  32'h8000_0000);
        send_cmd(OP_PUSH_FRONT, 7'd0,  32'hffff_ffff);
        send_cmd(OP_PUSH_BACK,  7'd0,  32'h0000_0000);
        send_cmd(OP_INSERT,     7'd4,  32'h8000_0000);
        send_cmd(OP_FIND,       7'd0,  32'h8000_0000);
        send_cmd(OP_FIND,       7'd0,  32'h0001_2345);
        send_cmd(OP_FIND,       7'd0,  32'h7fff_ffff);
        send_cmd(OP_INSERT,     7'd64, 32'h5555_aaaa);
        send_cmd(OP_ERASE,      7'd5,  32'h0000_0000);
        send_cmd(OP_ERASE,      7'd64, 32'h0000_0000);
        send_cmd(OP_ERASE,      7'd0,  32'h0000_0000);
        send_cmd(OP_ERASE,      7'd3,  32'h0000_0000);
        send_cmd(OP_POP_FRONT,  7'd0,  32'h0000_0000);
        send_cmd(OP_UNUSED,     7'd0,  32'h0000_0000);
        send_cmd(OP_POP_BACK,   7'd0,  32'h0000_0000);
        send_cmd(OP_FIND,       7'd0,  32'h8000_0000);

        // alternate fill and drain phases so full and empty are both hit
        for (int k = 0; k < N_RANDOM; k++) begin
            phase   = k / PHASE_LEN;
            no_idle = (phase % 3 == 2);
            if (k == HOLD_AT) hold_req = 1'b1;
            pick_cmd(phase % 2 == 0, op, pos, val);
            send_cmd(op, pos, val);
        end
        cmd_if.valid <= 1'b0;

        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/ale_pkg.sv
hdl/ale_if.sv
hdl/ale_cell.sv
hdl/ale_ctrl.sv
hdl/bounded_array_list_engine.sv
dv/testbench.sv
